// ===== sv/sflt_pkg.sv =====
package sflt_pkg;

    // operation codes
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_FAIL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_WINDOW  = 2'd1;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [7:0]  RST_MAX_FAILURES = 8'd5;
    localparam logic [16:0] RST_LOCK_WINDOW  = 17'd300;

    localparam logic [7:0]  FAILS_SAT = 8'hFF;
    localparam logic [31:0] DEADLINE_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] address_upper;
        logic [63:0] address_lower;
        logic        address_known;
        logic [31:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic [7:0]  max_failures;
        logic [16:0] lock_window;
    } t_cfg;

    // token handed from cell to cell during a scan
    typedef struct packed {
        logic act;        // scan token present
        logic hit;        // a matching entry has been seen
        logic locked;     // result of the matching entry
        logic free_seen;  // an unused entry has been seen
    } t_tok;

    typedef struct packed {
        logic [7:0]  failures;
        logic [31:0] deadline;
        logic        locked;
    } t_upd;

    // apply one operation to an entry's count and deadline
    function automatic t_upd f_apply(input logic [1:0] op, input logic [7:0] fails,
                                     input logic [31:0] dl, input logic [31:0] now,
                                     input t_cfg cfg);
        t_upd        u;
        logic [7:0]  nf;
        logic [32:0] sum;
        u.failures = fails;
        u.deadline = dl;
        u.locked   = 1'b0;
        nf  = (fails == FAILS_SAT) ? fails : fails + 8'd1;
        sum = {1'b0, now} + {16'd0, cfg.lock_window};
        case (op)
            OP_CHECK: begin
                if (dl != 32'd0) begin
                    if (now < dl) begin
                        u.locked = 1'b1;
                    end else begin
                        u.failures = 8'd0;
                        u.deadline = 32'd0;
                    end
                end
            end
            OP_FAIL: begin
                u.failures = nf;
                if (nf >= cfg.max_failures) begin
                    u.deadline = sum[32] ? DEADLINE_SAT : sum[31:0];
                end
            end
            OP_CLEAR: begin
                u.failures = 8'd0;
                u.deadline = 32'd0;
            end
            default: begin
            end
        endcase
        return u;
    endfunction

endpackage

// ===== sv/sflt_req_if.sv =====
interface sflt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] address_upper;
    logic [63:0] address_lower;
    logic        address_known;
    logic [31:0] now_seconds;

    modport source (
        output valid, operation, address_upper, address_lower, address_known, now_seconds,
        input  ready
    );
    modport sink (
        input  valid, operation, address_upper, address_lower, address_known, now_seconds,
        output ready
    );
endinterface

// ===== sv/sflt_rsp_if.sv =====
interface sflt_rsp_if;
    logic valid;
    logic ready;
    logic locked;

    modport source (output valid, locked, input ready);
    modport sink   (input valid, locked, output ready);
endinterface

// ===== sv/sflt_cell.sv =====
module sflt_cell #(
    parameter int unsigned IDX_W    = 5,
    parameter int unsigned CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sflt_pkg::t_req       i_req,
    input  sflt_pkg::t_cfg       i_cfg,
    input  sflt_pkg::t_tok       i_tok,
    input  logic [IDX_W-1:0]     i_free_idx,
    input  logic                 i_take,
    output sflt_pkg::t_tok       o_tok,
    output logic [IDX_W-1:0]     o_free_idx
);
    import sflt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // entry storage
    logic        r_used;
    logic        r_unk;
    logic [63:0] r_key_up;
    logic [63:0] r_key_lo;
    logic [7:0]  r_fails;
    logic [31:0] r_dl;

    t_tok             r_tok, n_tok;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;

    logic        w_match;
    logic        w_hit_here;
    logic        w_free_here;
    t_upd        w_upd;

    // key compare; unknown key matches only the unknown entry
    assign w_match = r_used & (i_req.address_known
                              ? (!r_unk && r_key_up == i_req.address_upper
                                        && r_key_lo == i_req.address_lower)
                              : r_unk);
    assign w_hit_here  = i_tok.act & !i_tok.hit & w_match;
    assign w_free_here = i_tok.act & !i_tok.free_seen & !r_used;

    // a freshly taken entry starts from zero count and deadline
    assign w_upd = f_apply(i_req.operation,
                           i_take ? 8'd0 : r_fails,
                           i_take ? 32'd0 : r_dl,
                           i_req.now_seconds, i_cfg);

    // token hand-on
    always_comb begin
        n_tok           = i_tok;
        n_tok.hit       = i_tok.hit | w_hit_here;
        n_tok.locked    = i_tok.locked | (w_hit_here & w_upd.locked);
        n_tok.free_seen = i_tok.free_seen | w_free_here;
        n_free_idx      = w_free_here ? MY_IDX : i_free_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_used <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_take) begin
                r_used <= 1'b1;
            end
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        if (i_take) begin
            r_unk    <= !i_req.address_known;
            r_key_up <= i_req.address_upper;
            r_key_lo <= i_req.address_lower;
        end
        if (i_take || w_hit_here) begin
            r_fails <= w_upd.failures;
            r_dl    <= w_upd.deadline;
        end
    end

    assign o_tok      = r_tok;
    assign o_free_idx = r_free_idx;

endmodule

// ===== sv/source_failure_lockout_table.sv =====
// Source failure lockout table: one entry per cell, scanned by a token.
// A request is accepted only while idle; the scan token then walks the cell chain one
// cell per cycle, a missed key takes an entry in S_TAKE, and S_FIN loads the result word;
// operation 3 skips the scan and goes straight to S_FIN. A new request is not taken
// until the result word of the last one has been handed to the output register.
// Reset (synchronous, active low) empties the table and restores registers.
module source_failure_lockout_table #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sflt_req_if.sink                           i_req,
    sflt_rsp_if.source                         o_rsp,
    input  logic                               i_cfg_we,
    input  logic [sflt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sflt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sflt_pkg::*;

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_TAKE = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_req             r_req;
    t_cfg             r_cfg;
    logic             r_start;
    logic             r_pend_locked;
    logic [IDX_W-1:0] r_take_idx;
    logic             r_out_valid;
    logic             r_out_locked;

    t_tok             w_tok  [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] w_free [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_take_sel;
    logic             w_accept;
    logic             w_out_free;
    t_tok             w_end;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid & i_req.ready;
    assign w_out_free  = !r_out_valid | o_rsp.ready;
    assign w_end       = w_tok[TABLE_ENTRIES];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_failures <= RST_MAX_FAILURES;
            r_cfg.lock_window  <= RST_LOCK_WINDOW;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_FAILURES: r_cfg.max_failures <= i_cfg_data[7:0];
                CFG_LOCK_WINDOW:  r_cfg.lock_window  <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.operation inside {OP_CHECK, OP_FAIL, OP_CLEAR})
                              ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (w_end.act) begin
                    n_state = w_end.hit ? S_FIN : S_TAKE;
                end
            end
            S_TAKE:  n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept && (n_state == S_SCAN);
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request hold, scan outcome and result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.operation     <= i_req.operation;
            r_req.address_upper <= i_req.address_upper;
            r_req.address_lower <= i_req.address_lower;
            r_req.address_known <= i_req.address_known;
            r_req.now_seconds   <= i_req.now_seconds;
            r_pend_locked       <= 1'b0;
        end
        if (r_state == S_SCAN && w_end.act) begin
            r_pend_locked <= w_end.hit & w_end.locked;
            r_take_idx    <= w_end.free_seen ? w_free[TABLE_ENTRIES] : '0;
        end
        if (r_state == S_FIN && w_out_free) begin
            r_out_locked <= r_pend_locked;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.locked = r_out_locked;

    // cell chain
    assign w_tok[0]  = '{act: r_start, hit: 1'b0, locked: 1'b0, free_seen: 1'b0};
    assign w_free[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        assign w_take_sel[g] = (r_state == S_TAKE) && (r_take_idx == IDX_W'(g));

        sflt_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_req      (r_req),
            .i_cfg      (r_cfg),
            .i_tok      (w_tok[g]),
            .i_free_idx (w_free[g]),
            .i_take     (w_take_sel[g]),
            .o_tok      (w_tok[g+1]),
            .o_free_idx (w_free[g+1])
        );
    end

    // at most one entry is taken at a time
    a_take_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_take_sel))
        else $error("more than one entry selected for take");

    // the scan token leaves the chain only while the sequencer waits for it
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.act |-> (r_state == S_SCAN))
        else $error("scan token outside scan state");

    // a locked answer only ever comes from a check
    a_lock_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_pend_locked) |-> (r_req.operation == OP_CHECK))
        else $error("locked result for non-check operation");

    // a take follows a scan that found no match
    a_take_after_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAKE) |-> ($past(r_state) == S_SCAN && !$past(w_end.hit)))
        else $error("take without a missed scan");

endmodule

// ===== tb/source_failure_lockout_table_test.sv =====
module source_failure_lockout_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sflt_pkg::*;

    localparam int unsigned SLOTS      = 32;
    localparam int unsigned POOL_KEYS  = 40;
    localparam int unsigned IDLE_LIMIT = 2000;

    // operation code the block ignores
    localparam logic [1:0] OP_NONE = 2'd3;
    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Lockout table predictor plus the queue of locked flags still owed by the block
    class lockout_tracker;
        bit          used       [SLOTS];
        bit          is_unknown [SLOTS];
        logic [63:0] key_hi     [SLOTS];
        logic [63:0] key_lo     [SLOTS];
        logic [7:0]  fails      [SLOTS];
        logic [31:0] deadline   [SLOTS];
        logic [7:0]  max_fails;
        logic [16:0] window;
        bit          pending_locked [$];
        int          errors;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            max_fails = RST_MAX_FAILURES;
            window    = RST_LOCK_WINDOW;
            errors    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_FAILURES: max_fails = data[7:0];
                CFG_LOCK_WINDOW:  window = data[16:0];
                default: begin
                end
            endcase
        endfunction

        // matching entry, else the lowest free one, else entry 0 is evicted
        function int unsigned locate(bit unknown, logic [63:0] hi, logic [63:0] lo);
            int unsigned slot;
            bit          found_free;
            slot       = 0;
            found_free = 1'b0;
            for (int unsigned i = 0; i < SLOTS; i++) begin
                if (!used[i]) begin
                    if (!found_free) begin
                        slot       = i;
                        found_free = 1'b1;
                    end
                end else if (unknown ? is_unknown[i]
                             : (!is_unknown[i] && key_hi[i] == hi && key_lo[i] == lo)) begin
                    return i;
                end
            end
            used[slot]       = 1'b1;
            is_unknown[slot] = unknown;
            key_hi[slot]     = unknown ? 64'd0 : hi;
            key_lo[slot]     = unknown ? 64'd0 : lo;
            fails[slot]      = 8'd0;
            deadline[slot]   = 32'd0;
            return slot;
        endfunction

        function void note_request(t_req r);
            bit          locked;
            int unsigned e;
            logic [32:0] reach;
            locked = 1'b0;
            if (r.operation != OP_NONE) begin
                e = locate(!r.address_known, r.address_upper, r.address_lower);
                case (r.operation)
                    OP_CHECK: begin
                        if (deadline[e] != 32'd0) begin
                            if (r.now_seconds < deadline[e]) begin
                                locked = 1'b1;
                            end else begin
                                fails[e]    = 8'd0;
                                deadline[e] = 32'd0;
                            end
                        end
                    end
                    OP_FAIL: begin
                        if (fails[e] != FAILS_SAT) fails[e] = fails[e] + 8'd1;
                        if (fails[e] >= max_fails) begin
                            reach = 33'(r.now_seconds) + 33'(window);
                            deadline[e] = (reach > 33'(DEADLINE_SAT)) ? DEADLINE_SAT
                                                                       : reach[31:0];
                        end
                    end
                    OP_CLEAR: begin
                        fails[e]    = 8'd0;
                        deadline[e] = 32'd0;
                    end
                    default: begin
                    end
                endcase
            end
            pending_locked.push_back(locked);
        endfunction

        function void check_locked(logic got);
            bit want;
            if (pending_locked.size() == 0) begin
                $display("%0t: result word with nothing outstanding, locked %0b", $time, got);
                errors++;
                return;
            end
            want = pending_locked.pop_front();
            if (got !== want) begin
                $display("%0t: locked mismatch: expected %0b, actual %0b", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sflt_req_if req_ch ();
    sflt_rsp_if rsp_ch ();

    lockout_tracker tracker = new();

    // key pool: 0 is the unknown key, 1 all zero, 2 all ones, 4 and 5 share a half with 3
    bit          pool_known [POOL_KEYS];
    logic [63:0] pool_hi    [POOL_KEYS];
    logic [63:0] pool_lo    [POOL_KEYS];

    bit          steady;
    int unsigned idle_cycles;
    logic [31:0] clock_now;

    source_failure_lockout_table #(
        .TABLE_ENTRIES (SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_req make_req(logic [1:0] op, logic known, logic [63:0] hi,
                                      logic [63:0] lo, logic [31:0] now);
        t_req r;
        r.operation     = op;
        r.address_known = known;
        r.address_upper = hi;
        r.address_lower = lo;
        r.now_seconds   = now;
        return r;
    endfunction

    // present one request word after a random gap and wait for it to be taken
    task automatic send_request(input t_req r);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= r.operation;
        req_ch.address_upper <= r.address_upper;
        req_ch.address_lower <= r.address_lower;
        req_ch.address_known <= r.address_known;
        req_ch.now_seconds   <= r.now_seconds;
        do @(posedge i_clk); while (!req_ch.ready);
        tracker.note_request(r);
    endtask

    // stop sending and let every owed result word come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (tracker.pending_locked.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_register(idx, data);
    endtask

    // both registers plus a stray write to an unused index; junk above the 8-bit limit
    task automatic write_settings(input logic [7:0] fmax, input logic [16:0] win);
        put_register(CFG_MAX_FAILURES, {9'($urandom), fmax});
        put_register(CFG_LOCK_WINDOW, win);
        put_register(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                     CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // random requests over a slice of the key pool, time mostly creeping forward
    task automatic run_phase(input int count, input int first_key, input int last_key,
                             input int fresh_pct, input int fail_pct, input int clear_pct,
                             input int none_pct, input int unsigned max_step,
                             input bit jumps);
        int unsigned pick;
        int unsigned k;
        logic [1:0]  op;
        logic        known;
        logic [63:0] hi;
        logic [63:0] lo;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 29) == 0) steady = !steady;
            pick = $urandom_range(0, 99);
            if (pick < fail_pct) op = OP_FAIL;
            else if (pick < fail_pct + clear_pct) op = OP_CLEAR;
            else if (pick < fail_pct + clear_pct + none_pct) op = OP_NONE;
            else op = OP_CHECK;
            pick = $urandom_range(0, 99);
            if (jumps && pick == 0) clock_now = $urandom();
            else if (jumps && pick == 1) clock_now = DEADLINE_SAT - $urandom_range(0, 300);
            else if (jumps && pick == 2) clock_now = 32'd0;
            else clock_now = clock_now + $urandom_range(0, max_step);
            if ($urandom_range(0, 99) < fresh_pct) begin
                known = 1'b1;
                hi    = {$urandom, $urandom};
                lo    = {$urandom, $urandom};
            end else begin
                k     = $urandom_range(first_key, last_key);
                known = pool_known[k];
                // halves of the unknown key are don't-care: drive noise
                hi    = known ? pool_hi[k] : {$urandom, $urandom};
                lo    = known ? pool_lo[k] : {$urandom, $urandom};
            end
            send_request(make_req(op, known, hi, lo, clock_now));
        end
    endtask

    // stimulus and end of run
    initial begin
        logic [7:0]  fmax;
        logic [16:0] win;
        req_ch.valid         <= 1'b0;
        req_ch.operation     <= OP_CHECK;
        req_ch.address_upper <= 64'd0;
        req_ch.address_lower <= 64'd0;
        req_ch.address_known <= 1'b0;
        req_ch.now_seconds   <= 32'd0;
        rsp_ch.ready         <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= CFG_MAX_FAILURES;
        i_cfg_data           <= '0;
        i_rst_n              <= 1'b0;
        steady    = 1'b0;
        clock_now = 32'd0;

        foreach (pool_known[i]) begin
            pool_known[i] = (i != 0);
            pool_hi[i]    = {$urandom, $urandom};
            pool_lo[i]    = {$urandom, $urandom};
        end
        pool_hi[1] = 64'd0;
        pool_lo[1] = 64'd0;
        pool_hi[2] = '1;
        pool_lo[2] = '1;
        pool_hi[4] = pool_hi[3];
        pool_lo[5] = pool_lo[3];

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings (5 failures, 300 s window)
        // unknown key must not match the all-zero known address
        send_request(make_req(OP_CHECK, 1'b0, '1, '1, 32'd0));
        for (int n = 0; n < 5; n++) send_request(make_req(OP_FAIL, 1'b1, 64'd0, 64'd0, 32'd100));
        send_request(make_req(OP_CHECK, 1'b1, 64'd0, 64'd0, 32'd399));
        send_request(make_req(OP_CHECK, 1'b0, 64'd0, 64'd0, 32'd399));
        send_request(make_req(OP_CHECK, 1'b1, '1, '1, 32'd400));
        // lock runs out exactly at the deadline and is cleared
        send_request(make_req(OP_CHECK, 1'b1, 64'd0, 64'd0, 32'd400));
        // deadline saturates near the top of time
        for (int n = 0; n < 5; n++) begin
            send_request(make_req(OP_FAIL, 1'b1, '1, '1, 32'hFFFF_FF00));
        end
        send_request(make_req(OP_CHECK, 1'b1, '1, '1, 32'hFFFF_FFFE));
        send_request(make_req(OP_NONE, 1'b1, '1, '1, 32'hFFFF_FFFF));
        send_request(make_req(OP_CHECK, 1'b1, '1, '1, 32'hFFFF_FFFE));
        send_request(make_req(OP_CLEAR, 1'b1, '1, '1, 32'hFFFF_FFFE));
        send_request(make_req(OP_CHECK, 1'b1, '1, '1, 32'hFFFF_FFFE));
        // key equal in one half only
        send_request(make_req(OP_CHECK, 1'b1, 64'd0, '1, 32'd0));

        // smallest nonzero settings: one failure locks for one second
        drain();
        write_settings(8'd1, 17'd1);
        run_phase(250, 0, 9, 5, 45, 10, 5, 3, 1'b1);

        // largest settings: one key hammered until the count saturates
        drain();
        write_settings(8'd255, 17'h1_FFFF);
        run_phase(300, 3, 3, 0, 92, 0, 3, 20, 1'b0);

        // zero limit and zero window, many keys so the table fills and evicts
        drain();
        write_settings(8'd0, 17'd0);
        run_phase(200, 0, 39, 25, 40, 10, 5, 2, 1'b1);

        drain();
        write_settings(8'd3, 17'd86400);
        run_phase(300, 0, 39, 10, 45, 10, 5, 30000, 1'b1);

        for (int p = 0; p < 3; p++) begin
            fmax = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(1, 8));
            win  = ($urandom_range(0, 1) == 0) ? 17'($urandom_range(0, 131071))
                                               : 17'($urandom_range(1, 500));
            drain();
            write_settings(fmax, win);
            run_phase(200, 0, 39, 10, 45, 10, 5, win / 4 + 1, 1'b1);
        end

        drain();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_locked.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // result side: random stalls that start once a word is waiting
    initial begin
        int unsigned stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                do @(posedge i_clk); while (!rsp_ch.valid);
                repeat (stall - 1) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
            tracker.check_locked(rsp_ch.locked);
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
